### sv/i2cws_pkg.sv
// Shared types and constants of the two-wire bus write sequencer.
`timescale 1ns / 1ps

package i2cws_pkg;

  // Byte width of the bus and of the message items.
  localparam int unsigned ByteW = 8;

  // Device byte after reset: device address with direction bit.
  localparam logic [ByteW-1:0] DevByteReset = 8'h1D;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One classified job, ready for the pin sequencer.
  typedef struct packed {
    logic             first;     // start, device byte, register byte
    logic             last;      // append stop
    logic [ByteW-1:0] dev_byte;  // device byte captured at accept time
    logic [ByteW-1:0] msg_byte;  // already shifted when first is set
  } job_t;

  // Queue occupancy as seen by its neighbors.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // One pin step.
  typedef struct packed {
    logic rel;
    logic sda;
    logic scl;
  } step_t;

endpackage

### sv/i2c_register_write_sequencer_unit.sv
// Top level of the two-wire bus write sequencer: front, job queue and pin sequencer.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata message byte, tuser first, tlast last
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata scl, sda, released; tlast end of run
// cfg      | in        | cfg_valid_i / cfg_ready_o      | cfg_data_i device byte
//
// A data byte gives 27 pin steps; a first item gives 57 and a last
// item adds 3 more, so an item gives 27 to 60 pin steps of the back sequencer.
// The pin sequencer emits one step per cycle when not stalled; a new job loads as the previous ends.
// Reset clears the queue, the sequencer and the output stage; device byte is 0x1D.
// A two-entry job queue lets input items be taken while the output stalls.

module i2c_register_write_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] message_byte
  input  logic       s_axis_tuser,   // [0] first_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] sda_released, zeros
  output logic       m_axis_tlast,   // end_of_run
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import i2cws_pkg::*;

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  job_t          push_job;
  job_t          head_job;
  step_t         out_step;

  i2cws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_msg_i    (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .q_status_i  (q_status),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  i2cws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .status_o   (q_status)
  );

  i2cws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_step_o  (out_step),
    .out_end_o   (m_axis_tlast)
  );

  // Pack the step fields from the lowest bit up.
  assign m_axis_tdata = {5'b0, out_step.rel, out_step.sda, out_step.scl};

endmodule

### sv/i2cws_front.sv
// Front part: configuration register and classification of input items into jobs.
`timescale 1ns / 1ps

module i2cws_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [i2cws_pkg::ByteW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [i2cws_pkg::ByteW-1:0] in_msg_i,
  input  logic                       in_first_i,
  input  logic                       in_last_i,
  input  i2cws_pkg::queue_status_t   q_status_i,
  output logic                       q_push_o,
  output i2cws_pkg::job_t            q_job_o
);
  import i2cws_pkg::*;

  logic [ByteW-1:0] dev_byte_q;

  // The device byte register takes a write whenever one is offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_byte_q <= DevByteReset;
    end else if (cfg_valid_i) begin
      dev_byte_q <= cfg_data_i;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_ready_o = !q_status_i.full;
  assign q_push_o   = in_valid_i && in_ready_o;

  // A first item carries a register address, which goes out shifted left by one.
  always_comb begin
    q_job_o.first    = in_first_i;
    q_job_o.last     = in_last_i;
    q_job_o.dev_byte = dev_byte_q;
    q_job_o.msg_byte = in_first_i ? {in_msg_i[ByteW-2:0], 1'b0} : in_msg_i;
  end

endmodule

### sv/i2cws_queue.sv
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module i2cws_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  i2cws_pkg::job_t          push_job_i,
  input  logic                     pop_i,
  output i2cws_pkg::job_t          head_job_o,
  output i2cws_pkg::queue_status_t status_o
);
  import i2cws_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign head_job_o     = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_o.full |-> !push_i)
    else $error("push into a full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_o.empty |-> !pop_i)
    else $error("pop from an empty queue");

  // The fill count grows by one on a push without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count did not grow on push");

endmodule

### sv/i2cws_back.sv
// Back part: pin step sequencer with a registered output stage.
`timescale 1ns / 1ps

module i2cws_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  i2cws_pkg::job_t          head_job_i,
  input  i2cws_pkg::queue_status_t q_status_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output i2cws_pkg::step_t         out_step_o,
  output logic                     out_end_o
);
  import i2cws_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhStart,
    PhByte,
    PhStop
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       bit_q, bit_d;      // 0..7 data bits, 8 acknowledge
  logic [1:0]       sub_q, sub_d;      // step within a bit
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ByteW-1:0] second_q, second_d;
  logic             final_byte_q, final_byte_d;
  logic             last_q, last_d;

  logic             out_valid_q;
  step_t            out_step_q;
  logic             out_end_q;

  logic             out_free;
  logic             emit;
  step_t            step;
  logic             step_end;
  logic             job_done;
  logic             load;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (phase_q != PhIdle) && out_free;

  // Pin levels of the current step.
  always_comb begin
    step     = '0;
    step_end = 1'b0;
    unique case (phase_q)
      PhStart: begin
        step.scl = (sub_q == 2'd0);
        step.sda = (sub_q == 2'd2);
      end
      PhByte: begin
        step.scl = (sub_q == 2'd1);
        if (bit_q == 4'd8) begin
          step.sda = 1'b1;
          step.rel = 1'b1;
          step_end = (sub_q == 2'd2) && final_byte_q && !last_q;
        end else begin
          step.sda = shift_q[ByteW-1];
        end
      end
      PhStop: begin
        step.scl = (sub_q != 2'd0);
        step.sda = (sub_q == 2'd2);
        step_end = (sub_q == 2'd2);
      end
      default: begin
        step = '0;
      end
    endcase
  end

  assign job_done = emit && step_end;
  assign load     = ((phase_q == PhIdle) || job_done) && !q_status_i.empty;
  assign q_pop_o  = load;

  // Sequencer advance; a new job loads in the cycle the previous one ends.
  always_comb begin
    phase_d      = phase_q;
    bit_d        = bit_q;
    sub_d        = sub_q;
    shift_d      = shift_q;
    second_d     = second_q;
    final_byte_d = final_byte_q;
    last_d       = last_q;
    if (emit) begin
      sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
      if (sub_q == 2'd2) begin
        unique case (phase_q)
          PhStart: begin
            phase_d = PhByte;
            bit_d   = 4'd0;
          end
          PhByte: begin
            if (bit_q != 4'd8) begin
              shift_d = {shift_q[ByteW-2:0], 1'b0};
              bit_d   = bit_q + 4'd1;
            end else if (!final_byte_q) begin
              shift_d      = second_q;
              final_byte_d = 1'b1;
              bit_d        = 4'd0;
            end else if (last_q) begin
              phase_d = PhStop;
            end else begin
              phase_d = PhIdle;
            end
          end
          PhStop: begin
            phase_d = PhIdle;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end
    if (job_done && !load) begin
      phase_d = PhIdle;
    end
    if (load) begin
      phase_d      = head_job_i.first ? PhStart : PhByte;
      bit_d        = 4'd0;
      sub_d        = 2'd0;
      shift_d      = head_job_i.first ? head_job_i.dev_byte : head_job_i.msg_byte;
      second_d     = head_job_i.msg_byte;
      final_byte_d = !head_job_i.first;
      last_d       = head_job_i.last;
    end
  end

  // Sequencer state and the output register, which holds a step until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      bit_q        <= 4'd0;
      sub_q        <= 2'd0;
      shift_q      <= '0;
      second_q     <= '0;
      final_byte_q <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_step_q   <= '0;
      out_end_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bit_q        <= bit_d;
      sub_q        <= sub_d;
      shift_q      <= shift_d;
      second_q     <= second_d;
      final_byte_q <= final_byte_d;
      last_q       <= last_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        out_step_q <= step;
        out_end_q  <= step_end;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_step_o  = out_step_q;
  assign out_end_o   = out_end_q;

  // The step counter never reaches its unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sub_q != 2'd3)
    else $error("step counter out of range");

  // The bit counter stops at the acknowledge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bit_q <= 4'd8)
    else $error("bit counter out of range");

  // A job is only loaded while the sequencer is free or ending a job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_pop_o |-> (phase_q == PhIdle || job_done))
    else $error("job loaded while another is running");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the two-wire bus write sequencer.
`timescale 1ns / 1ps

module tb_top;
  import i2cws_pkg::*;

  // One message item as it goes into the block.
  typedef struct packed {
    logic [ByteW-1:0] msg;
    logic             first;
    logic             last;
  } msg_item_t;

  // One expected pin step with its end-of-run marker.
  typedef struct packed {
    logic  eor;
    step_t pin;
  } pin_step_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  msg_item_t        pending_msgs[$];
  pin_step_t        pin_steps_due[$];
  msg_item_t        msg_in_flight;
  logic             msg_on_bus = 1'b0;
  logic [ByteW-1:0] dev_byte_model = DevByteReset;
  logic             idle_on = 1'b1;
  int unsigned      send_gap = 0;
  int unsigned      recv_stall = 0;
  int unsigned      errors = 0;

  i2c_register_write_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock generation.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Appends one pin step to the expected sequence.
  function automatic void add_pin_step(logic scl, logic sda, logic rel);
    pin_step_t s;
    s.eor = 1'b0;
    s.pin.scl = scl;
    s.pin.sda = sda;
    s.pin.rel = rel;
    pin_steps_due.push_back(s);
  endfunction

  // A byte goes out MSB first, three steps per bit, then the acknowledge clock.
  function automatic void add_byte_steps(logic [ByteW-1:0] b);
    for (int i = ByteW - 1; i >= 0; i--) begin
      add_pin_step(1'b0, b[i], 1'b0);
      add_pin_step(1'b1, b[i], 1'b0);
      add_pin_step(1'b0, b[i], 1'b0);
    end
    // The released line reads as the pulled-up level.
    add_pin_step(1'b0, 1'b1, 1'b1);
    add_pin_step(1'b1, 1'b1, 1'b1);
    add_pin_step(1'b0, 1'b1, 1'b1);
  endfunction

  // Works out every pin step that one accepted message item causes.
  function automatic void predict_pin_steps(msg_item_t it);
    pin_step_t tail;
    if (it.first) begin
      // A start always looks as if it came from an idle bus.
      add_pin_step(1'b1, 1'b0, 1'b0);
      add_pin_step(1'b0, 1'b0, 1'b0);
      add_pin_step(1'b0, 1'b1, 1'b0);
      add_byte_steps(dev_byte_model);
      add_byte_steps({it.msg[ByteW-2:0], 1'b0});
    end else begin
      add_byte_steps(it.msg);
    end
    if (it.last) begin
      add_pin_step(1'b0, 1'b0, 1'b0);
      add_pin_step(1'b1, 1'b0, 1'b0);
      add_pin_step(1'b1, 1'b1, 1'b0);
    end
    tail = pin_steps_due.pop_back();
    tail.eor = 1'b1;
    pin_steps_due.push_back(tail);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Message driver: takes items from the pending queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pin_steps(msg_in_flight);
        msg_on_bus = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 3);
          s_axis_tvalid <= 1'b0;
        end else if (pending_msgs.size() > 0) begin
          msg_in_flight = pending_msgs.pop_front();
          msg_on_bus = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= msg_in_flight.msg;
          s_axis_tuser <= msg_in_flight.first;
          s_axis_tlast <= msg_in_flight.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pin step monitor: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    pin_step_t exp_step;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pin_steps_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected pin step, expected none, actual tdata %h tlast %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_step = pin_steps_due.pop_front();
          check_field("scl_level", {7'd0, exp_step.pin.scl}, {7'd0, m_axis_tdata[0]});
          check_field("sda_level", {7'd0, exp_step.pin.sda}, {7'd0, m_axis_tdata[1]});
          check_field("sda_released", {7'd0, exp_step.pin.rel}, {7'd0, m_axis_tdata[2]});
          check_field("tdata padding", 8'd0, {3'd0, m_axis_tdata[7:3]});
          check_field("end_of_run", {7'd0, exp_step.eor}, {7'd0, m_axis_tlast});
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        recv_stall = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_msg(logic [7:0] msg, logic first, logic last);
    msg_item_t it;
    it.msg = msg;
    it.first = first;
    it.last = last;
    pending_msgs.push_back(it);
  endfunction

  // One well-formed transaction with random content, or now and then a random item.
  function automatic void queue_random_msgs();
    int unsigned n_data;
    if ($urandom_range(0, 6) == 0) begin
      queue_msg(8'($urandom), 1'($urandom), 1'($urandom));
    end else if ($urandom_range(0, 4) == 0) begin
      queue_msg(8'($urandom), 1'b1, 1'b1);
    end else begin
      n_data = $urandom_range(1, 3);
      queue_msg(8'($urandom), 1'b1, 1'b0);
      for (int i = 1; i <= n_data; i++) begin
        queue_msg(8'($urandom), 1'b0, 1'(i == n_data));
      end
    end
  endfunction

  // Waits until nothing is queued, on the bus or expected.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_msgs.size() > 0 || msg_on_bus || pin_steps_due.size() > 0);
  endtask

  // Writes the device byte over the configuration channel.
  task automatic write_device_byte(logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dev_byte_model = v;
  endtask

  // Stimulus sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed part with the reset device byte.
    queue_msg(8'h00, 1'b1, 1'b1);
    queue_msg(8'hFF, 1'b1, 1'b1);
    queue_msg(8'h80, 1'b1, 1'b1);
    queue_msg(8'h7F, 1'b1, 1'b1);
    queue_msg(8'hA5, 1'b1, 1'b0);
    queue_msg(8'h00, 1'b0, 1'b0);
    queue_msg(8'hFF, 1'b0, 1'b0);
    queue_msg(8'h5A, 1'b0, 1'b0);
    queue_msg(8'hC3, 1'b0, 1'b1);
    // Data bytes while no transaction is open.
    queue_msg(8'h3C, 1'b0, 1'b0);
    queue_msg(8'h81, 1'b0, 1'b1);
    // A start inside an open transaction.
    queue_msg(8'h11, 1'b1, 1'b0);
    queue_msg(8'h22, 1'b1, 1'b0);
    queue_msg(8'h96, 1'b0, 1'b1);
    queue_msg(8'h55, 1'b1, 1'b1);
    queue_msg(8'hAA, 1'b1, 1'b0);
    queue_msg(8'h01, 1'b0, 1'b1);
    wait_drained();

    // Random phases, each under its own device byte.
    write_device_byte(8'h00);
    while (pending_msgs.size() < 50) queue_random_msgs();
    wait_drained();

    write_device_byte(8'hFF);
    while (pending_msgs.size() < 50) queue_random_msgs();
    wait_drained();

    write_device_byte(8'($urandom_range(1, 254)));
    while (pending_msgs.size() < 50) queue_random_msgs();
    wait_drained();

    // Last stretch runs without any idling.
    write_device_byte(8'h1D);
    idle_on = 1'b0;
    while (pending_msgs.size() < 50) queue_random_msgs();
    wait_drained();
    repeat (80) @(posedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/i2cws_pkg.sv
sv/i2cws_front.sv
sv/i2cws_queue.sv
sv/i2cws_back.sv
sv/i2c_register_write_sequencer_unit.sv
tb/sv/tb_top.sv
